/* rtl/core/fdlnc_pkg.sv */
// ----------------------------------------------------------------------------
// fdlnc_pkg
// Shared types and constants of the lattice node classifier.
// ----------------------------------------------------------------------------
package fdlnc_pkg;

  localparam int NUM_COLUMNS = 16;
  localparam int ACTIVE_COLS = (NUM_COLUMNS < 16) ? NUM_COLUMNS : 16;
  localparam int BIT_W       = $clog2(ACTIVE_COLS);
  localparam int NODE_W      = 16;
  localparam int TABLE_DEPTH = 1 << NODE_W;
  localparam int CAT_W       = 3;

  localparam logic [NODE_W-1:0] NODE_MASK =
    NODE_W'((33'd1 << ACTIVE_COLS) - 33'd1);

  typedef enum logic [1:0] {
    CMD_DEP       = 2'd0,
    CMD_NONDEP    = 2'd1,
    CMD_QUERY     = 2'd2,
    CMD_QUERY_ALT = 2'd3
  } cmd_t;

  typedef enum logic [CAT_W-1:0] {
    CAT_UNCHECKED       = 3'd0,
    CAT_MIN_DEP         = 3'd1,
    CAT_DEP             = 3'd2,
    CAT_CAND_MIN_DEP    = 3'd3,
    CAT_MAX_NONDEP      = 3'd4,
    CAT_NONDEP          = 3'd5,
    CAT_CAND_MAX_NONDEP = 3'd6
  } cat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_QUERY
  } state_t;

  typedef struct packed {
    logic hit;
    logic unchk;
    logic seen_one;
    logic seen_two;
  } probe_flags_t;

endpackage

/* rtl/core/fd_lattice_node_classifier_unit.sv */
// ----------------------------------------------------------------------------
// fd_lattice_node_classifier_unit
// Dependency lattice node classifier over a category table of column sets.
//
// Input: a transaction is taken when start is high and busy is low. It
// carries in_command (classify dependency, classify non-dependency, query),
// in_column_set and in_rhs_index.
// Output: each transaction gives exactly one result, shown on out_category
// and out_is_candidate for one cycle with out_valid high. The receiver
// cannot stall; results are never held off.
// Sequence: a classify command scans one column per cycle through a single
// table read port, then a drain state folds the last read and writes the
// table, and the result is registered from the drain state. A query takes
// one table read, issued while idle, and its result is registered from the
// query state. busy stays high until the result is registered, so one
// transaction runs at a time.
// Reset: the table is cleared to unchecked by a pass over every entry, one
// entry per cycle, with busy high throughout.
// ----------------------------------------------------------------------------
module fd_lattice_node_classifier_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_command,
  input  logic [fdlnc_pkg::NODE_W-1:0]      in_column_set,
  input  logic [3:0]                        in_rhs_index,
  output logic                              out_valid,
  output logic [fdlnc_pkg::CAT_W-1:0]       out_category,
  output logic                              out_is_candidate
);
  import fdlnc_pkg::*;

  logic              ram_we;
  logic [NODE_W-1:0] ram_waddr;
  logic [CAT_W-1:0]  ram_wdata;
  logic [NODE_W-1:0] ram_raddr;
  logic [CAT_W-1:0]  ram_rdata;

  fdlnc_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_column_set    (in_column_set),
    .in_rhs_index     (in_rhs_index),
    .out_valid        (out_valid),
    .out_category     (out_category),
    .out_is_candidate (out_is_candidate),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  fdlnc_ram #(
    .WIDTH (CAT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/core/fdlnc_ram.sv */
// ----------------------------------------------------------------------------
// fdlnc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fdlnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/fdlnc_probe.sv */
// ----------------------------------------------------------------------------
// fdlnc_probe
// Shared probe unit: forms one neighbour address per step, folds the
// category read back into the running flags and resolves the final class.
// ----------------------------------------------------------------------------
module fdlnc_probe (
  input  fdlnc_pkg::cmd_t                     cmd,
  input  logic [fdlnc_pkg::NODE_W-1:0]        node,
  input  logic [fdlnc_pkg::ACTIVE_COLS-1:0]   probe_mask,
  input  logic [fdlnc_pkg::BIT_W-1:0]         bit_idx,
  input  logic                                pend,
  input  logic [fdlnc_pkg::CAT_W-1:0]         rd_data,
  input  fdlnc_pkg::probe_flags_t             flags_in,
  output logic                                probe_en,
  output logic [fdlnc_pkg::NODE_W-1:0]        probe_addr,
  output fdlnc_pkg::probe_flags_t             flags_out,
  output fdlnc_pkg::cat_t                     cat_final
);
  import fdlnc_pkg::*;

  logic [NODE_W-1:0] onehot;
  logic              dep_cmd;
  logic              same_kind;
  cat_t              rd_cat;
  probe_flags_t      eval_flags;

  assign dep_cmd  = (cmd == CMD_DEP);
  assign probe_en = probe_mask[bit_idx];
  assign onehot   = NODE_W'(1) << bit_idx;
  assign rd_cat   = cat_t'(rd_data);

  always_comb begin
    if (dep_cmd) begin
      probe_addr = node & ~onehot;
    end else begin
      probe_addr = node | onehot;
    end
  end

  always_comb begin
    if (dep_cmd) begin
      same_kind = (rd_cat == CAT_MIN_DEP) || (rd_cat == CAT_DEP) ||
                  (rd_cat == CAT_CAND_MIN_DEP);
    end else begin
      same_kind = (rd_cat == CAT_MAX_NONDEP) || (rd_cat == CAT_NONDEP) ||
                  (rd_cat == CAT_CAND_MAX_NONDEP);
    end
  end

  // fold the data of the probe issued in the previous cycle
  always_comb begin
    eval_flags = flags_in;
    if (pend) begin
      if (rd_cat == CAT_UNCHECKED) begin
        eval_flags.unchk = 1'b1;
      end else if (same_kind) begin
        eval_flags.hit = 1'b1;
      end
    end
  end

  // count node columns of a dependency command, saturating at two
  always_comb begin
    flags_out = eval_flags;
    if (probe_en && dep_cmd) begin
      flags_out.seen_one = 1'b1;
      flags_out.seen_two = flags_in.seen_two | flags_in.seen_one;
    end
  end

  always_comb begin
    if (dep_cmd) begin
      priority if (!eval_flags.seen_two) begin
        cat_final = CAT_MIN_DEP;
      end else if (eval_flags.hit) begin
        cat_final = CAT_DEP;
      end else if (eval_flags.unchk) begin
        cat_final = CAT_CAND_MIN_DEP;
      end else begin
        cat_final = CAT_MIN_DEP;
      end
    end else begin
      priority if (eval_flags.hit) begin
        cat_final = CAT_NONDEP;
      end else if (eval_flags.unchk) begin
        cat_final = CAT_CAND_MAX_NONDEP;
      end else begin
        cat_final = CAT_MAX_NONDEP;
      end
    end
  end

endmodule

/* rtl/core/fdlnc_seq.sv */
// ----------------------------------------------------------------------------
// fdlnc_seq
// Sequencer: table clearing pass, column scan over the shared probe unit,
// table update, query read and result register.
// ----------------------------------------------------------------------------
module fdlnc_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_command,
  input  logic [fdlnc_pkg::NODE_W-1:0]      in_column_set,
  input  logic [3:0]                        in_rhs_index,
  output logic                              out_valid,
  output logic [fdlnc_pkg::CAT_W-1:0]       out_category,
  output logic                              out_is_candidate,
  output logic                              ram_we,
  output logic [fdlnc_pkg::NODE_W-1:0]      ram_waddr,
  output logic [fdlnc_pkg::CAT_W-1:0]       ram_wdata,
  output logic [fdlnc_pkg::NODE_W-1:0]      ram_raddr,
  input  logic [fdlnc_pkg::CAT_W-1:0]       ram_rdata
);
  import fdlnc_pkg::*;

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [NODE_W-1:0]      node_r, node_nxt;
  logic [ACTIVE_COLS-1:0] mask_r, mask_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic                   pend_r, pend_nxt;
  probe_flags_t           flags_r, flags_nxt;
  logic [NODE_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CAT_W-1:0]       out_cat_r, out_cat_nxt;
  logic                   out_cand_r, out_cand_nxt;

  cmd_t                   in_cmd;
  logic [NODE_W-1:0]      in_node;
  logic [ACTIVE_COLS-1:0] rhs_excl;
  logic                   probe_en;
  logic [NODE_W-1:0]      probe_addr;
  probe_flags_t           flags_upd;
  cat_t                   cat_final;
  cat_t                   rd_cat;

  assign in_cmd  = cmd_t'(in_command);
  assign in_node = in_column_set & NODE_MASK;
  assign rd_cat  = cat_t'(ram_rdata);

  always_comb begin
    if (5'(in_rhs_index) < 5'(ACTIVE_COLS)) begin
      rhs_excl = ACTIVE_COLS'(1) << in_rhs_index;
    end else begin
      rhs_excl = '0;
    end
  end

  fdlnc_probe u_probe (
    .cmd        (cmd_r),
    .node       (node_r),
    .probe_mask (mask_r),
    .bit_idx    (bit_r),
    .pend       (pend_r),
    .rd_data    (ram_rdata),
    .flags_in   (flags_r),
    .probe_en   (probe_en),
    .probe_addr (probe_addr),
    .flags_out  (flags_upd),
    .cat_final  (cat_final)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    node_r     <= node_nxt;
    mask_r     <= mask_nxt;
    bit_r      <= bit_nxt;
    flags_r    <= flags_nxt;
    out_cat_r  <= out_cat_nxt;
    out_cand_r <= out_cand_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    node_nxt      = node_r;
    mask_nxt      = mask_r;
    bit_nxt       = bit_r;
    pend_nxt      = 1'b0;
    flags_nxt     = flags_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = 1'b0;
    out_cat_nxt   = out_cat_r;
    out_cand_nxt  = out_cand_r;
    ram_we        = 1'b0;
    ram_waddr     = node_r;
    ram_wdata     = cat_final;
    ram_raddr     = probe_addr;
    busy          = 1'b1;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = CAT_UNCHECKED;
        clr_addr_nxt = clr_addr_r + NODE_W'(1);
        if (&clr_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        busy      = 1'b0;
        ram_raddr = in_node;
        if (start) begin
          cmd_nxt   = in_cmd;
          node_nxt  = in_node;
          bit_nxt   = '0;
          flags_nxt = '0;
          unique case (in_cmd)
            CMD_DEP: begin
              mask_nxt  = in_node[ACTIVE_COLS-1:0];
              state_nxt = ST_SCAN;
            end
            CMD_NONDEP: begin
              mask_nxt  = ~in_node[ACTIVE_COLS-1:0] & ~rhs_excl;
              state_nxt = ST_SCAN;
            end
            CMD_QUERY, CMD_QUERY_ALT: begin
              state_nxt = ST_QUERY;
            end
          endcase
        end
      end

      ST_SCAN: begin
        pend_nxt  = probe_en;
        flags_nxt = flags_upd;
        bit_nxt   = bit_r + BIT_W'(1);
        if (bit_r == BIT_W'(ACTIVE_COLS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        ram_we        = 1'b1;
        out_valid_nxt = 1'b1;
        out_cat_nxt   = cat_final;
        out_cand_nxt  = (cat_final == CAT_CAND_MIN_DEP) ||
                        (cat_final == CAT_CAND_MAX_NONDEP);
        state_nxt     = ST_IDLE;
      end

      ST_QUERY: begin
        out_valid_nxt = 1'b1;
        out_cat_nxt   = ram_rdata;
        out_cand_nxt  = (rd_cat == CAT_CAND_MIN_DEP) ||
                        (rd_cat == CAT_CAND_MAX_NONDEP);
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_category     = out_cat_r;
  assign out_is_candidate = out_cand_r;

endmodule

/* bench/fdlnc_checker.sv */
// ----------------------------------------------------------------------------
// fdlnc_checker
// Watches the command and result channels of the lattice node classifier,
// keeps its own category table, predicts the category and candidate flag of
// every accepted transaction and compares each result with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module fdlnc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     in_command,
  input  logic [fdlnc_pkg::NODE_W-1:0]   in_column_set,
  input  logic [3:0]                     in_rhs_index,
  input  logic                           out_valid,
  input  logic [fdlnc_pkg::CAT_W-1:0]    out_category,
  input  logic                           out_is_candidate,
  output int                             fail_count,
  output int                             pending
);
  import fdlnc_pkg::*;

  typedef struct packed {
    cat_t category;
    logic is_candidate;
  } node_verdict_t;

  cat_t          cat_table [TABLE_DEPTH];
  node_verdict_t verdict_q [$];
  node_verdict_t oldest;
  logic [NODE_W-1:0] node;
  cat_t          new_cat;

  function automatic logic is_dep_cat(cat_t c);
    return c inside {CAT_MIN_DEP, CAT_DEP, CAT_CAND_MIN_DEP};
  endfunction

  function automatic logic is_nondep_cat(cat_t c);
    return c inside {CAT_MAX_NONDEP, CAT_NONDEP, CAT_CAND_MAX_NONDEP};
  endfunction

  function automatic cat_t classify_dep(logic [NODE_W-1:0] cols);
    int   width = 0;
    logic unchk = 1'b0;
    cat_t c;
    for (int b = 0; b < ACTIVE_COLS; b++) begin
      if (cols[b]) width++;
    end
    if (width <= 1) return CAT_MIN_DEP;
    for (int b = 0; b < ACTIVE_COLS; b++) begin
      if (cols[b]) begin
        c = cat_table[cols & ~(NODE_W'(1) << b)];
        if (c == CAT_UNCHECKED) unchk = 1'b1;
        else if (is_dep_cat(c)) return CAT_DEP;
      end
    end
    return unchk ? CAT_CAND_MIN_DEP : CAT_MIN_DEP;
  endfunction

  function automatic cat_t classify_nondep(logic [NODE_W-1:0] cols, logic [3:0] rhs);
    logic [NODE_W-1:0] free_cols = ~cols & NODE_MASK;
    logic              unchk     = 1'b0;
    cat_t              c;
    if (int'(rhs) < ACTIVE_COLS) free_cols[rhs] = 1'b0;
    for (int b = 0; b < ACTIVE_COLS; b++) begin
      if (free_cols[b]) begin
        c = cat_table[cols | (NODE_W'(1) << b)];
        if (c == CAT_UNCHECKED) unchk = 1'b1;
        else if (is_nondep_cat(c)) return CAT_NONDEP;
      end
    end
    return unchk ? CAT_CAND_MAX_NONDEP : CAT_MAX_NONDEP;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (cat_table[i]) cat_table[i] = CAT_UNCHECKED;
      verdict_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual category %0d cand %0b",
                   $time, out_category, out_is_candidate);
          fail_count++;
        end else begin
          oldest = verdict_q.pop_front();
          if (out_category !== oldest.category) begin
            $display("%0t: category mismatch: expected %0d, actual %0d",
                     $time, oldest.category, out_category);
            fail_count++;
          end
          if (out_is_candidate !== oldest.is_candidate) begin
            $display("%0t: is_candidate mismatch: expected %0b, actual %0b",
                     $time, oldest.is_candidate, out_is_candidate);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        node = in_column_set & NODE_MASK;
        case (cmd_t'(in_command))
          CMD_DEP: begin
            new_cat = classify_dep(node);
            cat_table[node] = new_cat;
          end
          CMD_NONDEP: begin
            new_cat = classify_nondep(node, in_rhs_index);
            cat_table[node] = new_cat;
          end
          default: begin
            new_cat = cat_table[node];
          end
        endcase
        verdict_q.push_back('{category: new_cat,
                              is_candidate: (new_cat == CAT_CAND_MIN_DEP) ||
                                            (new_cat == CAT_CAND_MAX_NONDEP)});
      end
    end
    pending = verdict_q.size();
  end

endmodule

/* bench/fd_lattice_node_classifier_unit_tb.sv */
// ----------------------------------------------------------------------------
// fd_lattice_node_classifier_unit_tb
// Drives directed and random classify and query commands into the lattice
// node classifier, with random idle gaps, and reports the checker's verdict.
// Random nodes are mostly drawn from small column universes so that subsets
// and supersets of earlier nodes are probed.
// ----------------------------------------------------------------------------
module fd_lattice_node_classifier_unit_tb;
  import fdlnc_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_ITEMS = 2000;
  localparam int RUN_LIMIT    = CLK_PERIOD * 1000000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_command;
  logic [NODE_W-1:0] in_column_set;
  logic [3:0]        in_rhs_index;
  logic              out_valid;
  logic [CAT_W-1:0]  out_category;
  logic              out_is_candidate;
  int                fail_count;
  int                pending;
  logic              no_gaps;

  fd_lattice_node_classifier_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_column_set    (in_column_set),
    .in_rhs_index     (in_rhs_index),
    .out_valid        (out_valid),
    .out_category     (out_category),
    .out_is_candidate (out_is_candidate)
  );

  fdlnc_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_column_set    (in_column_set),
    .in_rhs_index     (in_rhs_index),
    .out_valid        (out_valid),
    .out_category     (out_category),
    .out_is_candidate (out_is_candidate),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_node(cmd_t cmd, logic [NODE_W-1:0] cols, logic [3:0] rhs);
    int r   = $urandom_range(0, 99);
    int len = 0;
    if (!no_gaps) begin
      if (r >= 85) len = $urandom_range(21, 120);
      else if (r >= 40) len = $urandom_range(1, 20);
    end
    repeat (len) begin
      start         <= 1'b0;
      in_command    <= 2'($urandom);
      in_column_set <= NODE_W'($urandom);
      in_rhs_index  <= 4'($urandom);
      @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_column_set <= cols;
    in_rhs_index  <= rhs;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [NODE_W-1:0] pick_universe();
    logic [NODE_W-1:0] u = '0;
    int                k = $urandom_range(3, 7);
    if ($urandom_range(0, 9) == 0) return NODE_W'($urandom);
    while ($countones(u) < k) u[$urandom_range(0, NODE_W - 1)] = 1'b1;
    return u;
  endfunction

  initial begin : stimulus
    logic [NODE_W-1:0] universe;
    logic [NODE_W-1:0] cols;
    logic [3:0]        rhs;
    cmd_t              cmd;
    int                r;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_command    <= CMD_DEP;
    in_column_set <= '0;
    in_rhs_index  <= '0;
    no_gaps        = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_node(CMD_DEP,       16'h0000, 4'd0);
    send_node(CMD_DEP,       16'h0001, 4'd0);
    send_node(CMD_QUERY,     16'h0001, 4'd9);
    send_node(CMD_DEP,       16'h0003, 4'd0);
    send_node(CMD_DEP,       16'h0006, 4'd0);
    send_node(CMD_QUERY_ALT, 16'h0006, 4'd0);
    send_node(CMD_DEP,       16'h8000, 4'd15);
    send_node(CMD_DEP,       16'hFFFF, 4'd0);
    send_node(CMD_NONDEP,    16'hFFFF, 4'd0);
    send_node(CMD_NONDEP,    16'hFFFE, 4'd0);
    send_node(CMD_NONDEP,    16'h7FFF, 4'd15);
    send_node(CMD_NONDEP,    16'hFFF0, 4'd2);
    send_node(CMD_NONDEP,    16'h7FFE, 4'd3);
    send_node(CMD_NONDEP,    16'h0007, 4'd1);
    send_node(CMD_QUERY,     16'hFFFF, 4'd0);
    send_node(CMD_QUERY,     16'h0000, 4'd0);
    send_node(CMD_DEP,       16'h0002, 4'd0);
    send_node(CMD_DEP,       16'h0004, 4'd0);
    send_node(CMD_DEP,       16'h0006, 4'd0);
    send_node(CMD_NONDEP,    16'h1234, 4'd15);
    send_node(CMD_QUERY,     16'hABCD, 4'd0);
    send_node(CMD_DEP,       16'h5555, 4'd0);
    send_node(CMD_NONDEP,    16'hAAAA, 4'd4);
    send_node(CMD_QUERY_ALT, 16'hAAAA, 4'd7);

    universe = pick_universe();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 149) universe = pick_universe();
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 9) < 3);
      r = $urandom_range(0, 99);
      if (r < 40) cmd = CMD_DEP;
      else if (r < 75) cmd = CMD_NONDEP;
      else if (r < 95) cmd = CMD_QUERY;
      else cmd = CMD_QUERY_ALT;
      rhs = 4'($urandom);
      if ($urandom_range(0, 1) == 1) begin
        for (int t = 0; t < 32 && !universe[rhs]; t++) rhs = 4'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 85) cols = universe & NODE_W'($urandom);
      else if (r < 95) cols = NODE_W'($urandom);
      else if (r < 98) cols = NODE_MASK & ~(NODE_W'(1) << rhs);
      else cols = NODE_MASK;
      send_node(cmd, cols, rhs);
    end
    start <= 1'b0;

    for (int i = 0; i < 4 * (ACTIVE_COLS + 2) && pending != 0; i++) @(posedge clk);
    repeat (ACTIVE_COLS + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* fd_lattice_node_classifier_unit.f */
rtl/core/fdlnc_pkg.sv
rtl/core/fdlnc_ram.sv
rtl/core/fdlnc_probe.sv
rtl/core/fdlnc_seq.sv
rtl/core/fd_lattice_node_classifier_unit.sv
bench/fdlnc_checker.sv
bench/fd_lattice_node_classifier_unit_tb.sv
